FILE: rtl/slu_pkg.sv
`timescale 1ns / 1ps

package slu_pkg;

    // Most result transactions that one input byte can cause
    localparam int MAX_RES  = 6;
    // Most results from the byte itself, before end-of-string handling
    localparam int MAIN_RES = 4;
    // Most results from end-of-string handling
    localparam int FIN_RES  = 3;

    // Result kinds
    localparam logic [2:0] K_LIT   = 3'd0;
    localparam logic [2:0] K_IDENT = 3'd1;
    localparam logic [2:0] K_SEG   = 3'd2;
    localparam logic [2:0] K_DONE  = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // Error codes
    localparam logic [2:0] E_NONE          = 3'd0;
    localparam logic [2:0] E_UNTERMINATED  = 3'd1;
    localparam logic [2:0] E_UNSUPPORTED   = 3'd2;
    localparam logic [2:0] E_INCOMPLETE    = 3'd3;
    localparam logic [2:0] E_BAD_HEX       = 3'd4;
    localparam logic [2:0] E_BAD_PAIR      = 3'd5;
    localparam logic [2:0] E_LONE_LOW      = 3'd6;

    // Decoder modes
    localparam logic [3:0] M_PLAIN    = 4'd0;
    localparam logic [3:0] M_HASH     = 4'd1;
    localparam logic [3:0] M_IDENT    = 4'd2;
    localparam logic [3:0] M_ESC      = 4'd3;
    localparam logic [3:0] M_HEX1     = 4'd4;
    localparam logic [3:0] M_WANT_BSL = 4'd5;
    localparam logic [3:0] M_WANT_U   = 4'd6;
    localparam logic [3:0] M_HEX2     = 4'd7;
    localparam logic [3:0] M_DRAIN    = 4'd8;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } res_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] acc;
        logic [2:0]  digits;
        logic        bad;
        logic [9:0]  high_bits;
        logic        nonempty;
    } state_t;

    // Plain mode is code zero, so the reset state is all zeros
    localparam state_t STATE_RESET = '0;

endpackage

FILE: rtl/slu_decode.sv
`timescale 1ns / 1ps

module slu_decode (
    input  slu_pkg::state_t state,
    input  logic [7:0]      content_byte,
    input  logic            final_byte,
    output slu_pkg::state_t state_next,
    output slu_pkg::res_t   results [slu_pkg::MAX_RES],
    output logic [2:0]      result_count
);
    import slu_pkg::*;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    function automatic res_t mk_res(input logic [2:0] k, input logic [7:0] d,
                                    input logic [2:0] e);
        res_t r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        return r;
    endfunction

    function automatic logic id_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic id_part(input logic [7:0] c);
        return id_start(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Bit 4 set marks a byte that is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
        else t = 8'h10;
        return t[4:0];
    endfunction

    function automatic utf8_t utf8(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp <= 21'h7F) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    state_t      st;
    res_t        m_res [MAIN_RES];
    res_t        f_res [FIN_RES];
    logic [2:0]  m_n;
    logic [2:0]  f_n;
    logic [3:0]  pb_mode;
    logic        pb_emit;
    logic [4:0]  digit;
    logic [15:0] acc_new;
    logic [2:0]  cnt_new;
    logic        bad_new;
    logic        cp_emit;
    logic [20:0] cp;
    utf8_t       enc;

    // What a byte does in plain mode
    always_comb
    begin
        pb_emit = 1'b0;
        if (content_byte == CH_BSL) pb_mode = M_ESC;
        else if (content_byte == CH_HASH) pb_mode = M_HASH;
        else
        begin
            pb_mode = M_PLAIN;
            pb_emit = 1'b1;
        end
    end

    // Hex digit accumulation
    always_comb
    begin
        digit   = hex_val(content_byte);
        acc_new = {state.acc[11:0], (digit[4] ? 4'd0 : digit[3:0])};
        cnt_new = state.digits + 3'd1;
        bad_new = state.bad | digit[4];
    end

    always_comb
    begin
        st      = state;
        m_n     = 3'd0;
        cp_emit = 1'b0;
        cp      = '0;
        for (int i = 0; i < MAIN_RES; i++) m_res[i] = '0;

        unique case (state.mode)
            M_HASH:
            begin
                if (id_start(content_byte))
                begin
                    if (state.nonempty)
                    begin
                        m_res[m_n[1:0]] = mk_res(K_SEG, 8'h00, E_NONE);
                        m_n = m_n + 3'd1;
                    end
                    m_res[m_n[1:0]] = mk_res(K_IDENT, content_byte, E_NONE);
                    m_n = m_n + 3'd1;
                    st.nonempty = 1'b0;
                    st.mode = M_IDENT;
                end
                else
                begin
                    m_res[0] = mk_res(K_LIT, CH_HASH, E_NONE);
                    m_n = 3'd1;
                    st.nonempty = 1'b1;
                    st.mode = pb_mode;
                    if (pb_emit)
                    begin
                        m_res[1] = mk_res(K_LIT, content_byte, E_NONE);
                        m_n = 3'd2;
                    end
                end
            end
            M_IDENT:
            begin
                if (id_part(content_byte))
                begin
                    m_res[0] = mk_res(K_IDENT, content_byte, E_NONE);
                    m_n = 3'd1;
                end
                else
                begin
                    m_res[0] = mk_res(K_SEG, 8'h00, E_NONE);
                    m_n = 3'd1;
                    st.mode = pb_mode;
                    if (pb_emit)
                    begin
                        m_res[1] = mk_res(K_LIT, content_byte, E_NONE);
                        m_n = 3'd2;
                        st.nonempty = 1'b1;
                    end
                end
            end
            M_ESC:
            begin
                st.mode = M_PLAIN;
                m_n = 3'd1;
                unique case (content_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH, CH_HASH:
                        m_res[0] = mk_res(K_LIT, content_byte, E_NONE);
                    CH_B: m_res[0] = mk_res(K_LIT, 8'h08, E_NONE);
                    CH_F: m_res[0] = mk_res(K_LIT, 8'h0C, E_NONE);
                    CH_N: m_res[0] = mk_res(K_LIT, 8'h0A, E_NONE);
                    CH_R: m_res[0] = mk_res(K_LIT, 8'h0D, E_NONE);
                    CH_T: m_res[0] = mk_res(K_LIT, 8'h09, E_NONE);
                    CH_U:
                    begin
                        m_n       = 3'd0;
                        st.acc    = '0;
                        st.digits = '0;
                        st.bad    = 1'b0;
                        st.mode   = M_HEX1;
                    end
                    default:
                    begin
                        m_res[0] = mk_res(K_ERR, 8'h00, E_UNSUPPORTED);
                        st.mode  = M_DRAIN;
                    end
                endcase
                if (st.mode == M_PLAIN) st.nonempty = 1'b1;
            end
            M_HEX1, M_HEX2:
            begin
                st.acc    = acc_new;
                st.digits = cnt_new;
                st.bad    = bad_new;
                if (cnt_new >= 3'd4)
                begin
                    st.acc    = '0;
                    st.digits = '0;
                    if (bad_new)
                    begin
                        st.bad   = 1'b0;
                        m_res[0] = mk_res(K_ERR, 8'h00, E_BAD_HEX);
                        m_n      = 3'd1;
                        st.mode  = M_DRAIN;
                    end
                    else if (state.mode == M_HEX1)
                    begin
                        if (acc_new[15:10] == HIGH_SURR_TAG)
                        begin
                            st.high_bits = acc_new[9:0];
                            st.mode      = M_WANT_BSL;
                        end
                        else if (acc_new[15:10] == LOW_SURR_TAG)
                        begin
                            m_res[0] = mk_res(K_ERR, 8'h00, E_LONE_LOW);
                            m_n      = 3'd1;
                            st.mode  = M_DRAIN;
                        end
                        else
                        begin
                            cp      = {5'd0, acc_new};
                            cp_emit = 1'b1;
                            st.mode = M_PLAIN;
                        end
                    end
                    else
                    begin
                        if (acc_new[15:10] == LOW_SURR_TAG)
                        begin
                            cp      = SUPP_BASE + {1'b0, state.high_bits, acc_new[9:0]};
                            cp_emit = 1'b1;
                            st.mode = M_PLAIN;
                        end
                        else
                        begin
                            m_res[0] = mk_res(K_ERR, 8'h00, E_BAD_PAIR);
                            m_n      = 3'd1;
                            st.mode  = M_DRAIN;
                        end
                    end
                end
            end
            M_WANT_BSL:
            begin
                if (content_byte == CH_BSL) st.mode = M_WANT_U;
                else
                begin
                    m_res[0] = mk_res(K_ERR, 8'h00, E_BAD_PAIR);
                    m_n      = 3'd1;
                    st.mode  = M_DRAIN;
                end
            end
            M_WANT_U:
            begin
                if (content_byte == CH_U)
                begin
                    st.acc    = '0;
                    st.digits = '0;
                    st.bad    = 1'b0;
                    st.mode   = M_HEX2;
                end
                else
                begin
                    m_res[0] = mk_res(K_ERR, 8'h00, E_BAD_PAIR);
                    m_n      = 3'd1;
                    st.mode  = M_DRAIN;
                end
            end
            M_DRAIN: ;
            default:
            begin
                st.mode = pb_mode;
                if (pb_emit)
                begin
                    m_res[0] = mk_res(K_LIT, content_byte, E_NONE);
                    m_n = 3'd1;
                    st.nonempty = 1'b1;
                end
            end
        endcase

        enc = utf8(cp);
        if (cp_emit)
        begin
            for (int i = 0; i < MAIN_RES; i++)
                m_res[i] = mk_res(K_LIT, enc.bytes[i], E_NONE);
            m_n = enc.len;
            st.nonempty = 1'b1;
        end
    end

    // End of string: close segments or report what is left open
    always_comb
    begin
        f_n = 3'd0;
        for (int i = 0; i < FIN_RES; i++) f_res[i] = '0;
        if (final_byte)
        begin
            unique case (st.mode)
                M_DRAIN: ;
                M_ESC:
                begin
                    f_res[0] = mk_res(K_ERR, 8'h00, E_UNTERMINATED);
                    f_n = 3'd1;
                end
                M_HEX1, M_HEX2:
                begin
                    f_res[0] = mk_res(K_ERR, 8'h00, E_INCOMPLETE);
                    f_n = 3'd1;
                end
                M_WANT_BSL, M_WANT_U:
                begin
                    f_res[0] = mk_res(K_ERR, 8'h00, E_BAD_PAIR);
                    f_n = 3'd1;
                end
                M_IDENT:
                begin
                    f_res[0] = mk_res(K_SEG, 8'h00, E_NONE);
                    f_res[1] = mk_res(K_DONE, 8'h00, E_NONE);
                    f_n = 3'd2;
                end
                M_HASH:
                begin
                    f_res[0] = mk_res(K_LIT, CH_HASH, E_NONE);
                    f_res[1] = mk_res(K_SEG, 8'h00, E_NONE);
                    f_res[2] = mk_res(K_DONE, 8'h00, E_NONE);
                    f_n = 3'd3;
                end
                default:
                begin
                    if (st.nonempty)
                    begin
                        f_res[0] = mk_res(K_SEG, 8'h00, E_NONE);
                        f_res[1] = mk_res(K_DONE, 8'h00, E_NONE);
                        f_n = 3'd2;
                    end
                    else
                    begin
                        f_res[0] = mk_res(K_DONE, 8'h00, E_NONE);
                        f_n = 3'd1;
                    end
                end
            endcase
        end
    end

    // Pack the byte's own results, then the end-of-string results behind them
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++) results[i] = '0;
        for (int i = 0; i < MAIN_RES; i++)
            if (3'(i) < m_n) results[i] = m_res[i];
        for (int i = 0; i < MAX_RES; i++)
        begin
            for (int j = 0; j < FIN_RES; j++)
                if (3'(j) < f_n && 3'(i) == m_n + 3'(j)) results[i] = f_res[j];
        end
        result_count = m_n + f_n;
        state_next   = final_byte ? STATE_RESET : st;
    end

endmodule

FILE: rtl/string_literal_unescape_utf8.sv
`timescale 1ns / 1ps

// String literal unescaper with UTF-8 output.
//
// Item channel (item_valid / item_ready): one raw content byte of a string
// literal per transaction, with final_byte set on the last byte of a string.
// Result channel (result_valid / result_ready): one tagged byte or marker per
// transaction (kind, data_byte, error_code); run_last flags the last result
// caused by an input byte. A byte may cause zero to six results.
//
// A byte's first result is presented in the cycle after its transaction. One
// input byte per cycle is taken while each byte yields at most one result and
// the receiver is ready; a byte with more results holds the item channel until
// its last result leaves the single result register, which drains one entry
// per cycle while the receiver is ready. Bytes with no result pass one per cycle.
//
// Reset clears the decoder to plain literal mode and empties the result
// register. A stalled receiver holds the current result; the next byte is
// taken as soon as the last pending result leaves.
module string_literal_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] content_byte,
    input  logic       final_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [2:0] error_code,
    output logic       run_last
);
    import slu_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    res_t       dec_results [MAX_RES];
    logic [2:0] dec_count;

    // Pending results of the last accepted byte, head in slot 0
    res_t       burst_reg [MAX_RES];
    logic [2:0] count_reg;
    logic [2:0] count_next;

    logic item_take;
    logic result_take;

    slu_decode u_decode (
        .state        (state_reg),
        .content_byte (content_byte),
        .final_byte   (final_byte),
        .state_next   (state_next),
        .results      (dec_results),
        .result_count (dec_count)
    );

    // Accept a new byte once the result register is empty or its last entry
    // leaves in this cycle
    assign item_ready  = (count_reg == 3'd0) || (count_reg == 3'd1 && result_ready);
    assign item_take   = item_valid && item_ready;
    assign result_take = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (item_take) count_next = dec_count;
        else if (result_take) count_next = count_reg - 3'd1;
    end

    // Decoder state advances on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            count_reg <= 3'd0;
        end
        else
        begin
            if (item_take) state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Load a fresh burst, or shift the pending one down as results leave
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            for (int i = 0; i < MAX_RES; i++) burst_reg[i] <= dec_results[i];
        end
        else if (result_take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++) burst_reg[i] <= burst_reg[i + 1];
        end
    end

    assign result_valid = (count_reg != 3'd0);
    assign run_last     = (count_reg == 3'd1);
    assign kind         = burst_reg[0].kind;
    assign data_byte    = burst_reg[0].data;
    assign error_code   = burst_reg[0].err;

endmodule
